### design/clcd_pkg.sv
// Shared types and constants for the character LCD nibble writer.
// No dependencies; every other design file imports this package.
package clcd_pkg;

    typedef enum logic [1:0] {
        CMD_INSTR  = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_CURSOR = 2'd2,
        CMD_NUMBER = 2'd3
    } t_cmd;

    localparam int NUM_BITS   = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(NUM_BITS);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [7:0] LINE1_OFFSET = 8'h40;
    localparam logic [7:0] SET_DDRAM    = 8'h80;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    localparam logic       RS_INSTR = 1'b0;
    localparam logic       RS_DATA  = 1'b1;

    typedef logic [IDX_W-1:0] t_digit_idx;
    typedef logic [BCD_W-1:0] t_bcd;

endpackage

### design/clcd_req_if.sv
// Request channel of the character LCD nibble writer: valid, ready and one request.
// Depends on clcd_pkg.
interface clcd_req_if
    import clcd_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  byte_value;
    logic [5:0]  column;
    logic        row;
    logic [31:0] number;

    modport source (output valid, command, byte_value, column, row, number, input ready);
    modport sink   (input valid, command, byte_value, column, row, number, output ready);
endinterface

### design/clcd_strobe_if.sv
// Strobe channel of the character LCD nibble writer: one enable strobe per beat.
// Depends on clcd_pkg.
interface clcd_strobe_if
    import clcd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [3:0] nibble;
    logic       last;

    modport source (output valid, register_select, nibble, last, input ready);
    modport sink   (input valid, register_select, nibble, last, output ready);
endinterface

### design/clcd_bcd.sv
// Binary to BCD converter, one shift-and-add-three step per cycle.
// Depends on clcd_pkg.
module clcd_bcd
    import clcd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_value,
    output logic                o_done,
    output t_bcd                o_bcd
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_BITS-1:0] r_bin;
    t_bcd                r_bcd;
    t_bcd                w_adj;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                w_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[NUM_BITS-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[NUM_BITS-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

### design/char_lcd_nibble_writer.sv
// Character LCD nibble writer, top level: request channel in, strobe channel out.
// Depends on clcd_pkg, clcd_req_if, clcd_strobe_if and clcd_bcd.
//
// Each request becomes a series of strobe beats, one byte as two beats, high
// nibble first. Command, data and set-cursor requests are accepted from idle
// and then sent as two beats. A number request first holds the block while
// clcd_bcd converts it from binary to BCD (32 shift steps, then a registered
// done flag), then skips leading zero digits (up to nine) and loads the first
// digit, then sends two beats per digit. One request is handled at a time,
// and the request channel is ready only while the block is idle.
module char_lcd_nibble_writer
    import clcd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    clcd_req_if.sink      i_req,
    clcd_strobe_if.source o_lcd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_SEND = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_byte, n_byte;
    logic       r_rs, n_rs;
    logic       r_hi, n_hi;
    logic       r_final, n_final;
    logic       r_is_num, n_is_num;
    t_digit_idx r_idx, n_idx;

    logic       w_start;
    logic       w_done;
    t_bcd       w_bcd;
    logic [3:0] w_digit;
    logic [3:0] w_next_digit;
    t_cmd       w_cmd;
    logic [7:0] w_addr;
    t_digit_idx w_idx_dec;

    clcd_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (i_req.number),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    assign w_cmd        = t_cmd'(i_req.command);
    assign w_addr       = SET_DDRAM + (i_req.row ? LINE1_OFFSET : 8'h00)
                        + {2'b00, i_req.column};
    assign w_idx_dec    = r_idx - 1'b1;
    assign w_digit      = w_bcd[{r_idx, 2'b00} +: 4];
    assign w_next_digit = w_bcd[{w_idx_dec, 2'b00} +: 4];

    assign i_req.ready = (r_state == S_IDLE);
    assign w_start     = i_req.valid && i_req.ready && (w_cmd == CMD_NUMBER);

    assign o_lcd.valid           = (r_state == S_SEND);
    assign o_lcd.register_select = r_rs;
    assign o_lcd.nibble          = r_hi ? r_byte[7:4] : r_byte[3:0];
    assign o_lcd.last            = !r_hi && r_final;

    always_comb begin
        n_state  = r_state;
        n_byte   = r_byte;
        n_rs     = r_rs;
        n_hi     = r_hi;
        n_final  = r_final;
        n_is_num = r_is_num;
        n_idx    = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_hi    = 1'b1;
                    n_final = 1'b1;
                    unique case (w_cmd)
                        CMD_INSTR: begin
                            n_byte   = i_req.byte_value;
                            n_rs     = RS_INSTR;
                            n_is_num = 1'b0;
                            n_state  = S_SEND;
                        end
                        CMD_DATA: begin
                            n_byte   = i_req.byte_value;
                            n_rs     = RS_DATA;
                            n_is_num = 1'b0;
                            n_state  = S_SEND;
                        end
                        CMD_CURSOR: begin
                            n_byte   = w_addr;
                            n_rs     = RS_INSTR;
                            n_is_num = 1'b0;
                            n_state  = S_SEND;
                        end
                        CMD_NUMBER: begin
                            n_rs     = RS_DATA;
                            n_is_num = 1'b1;
                            n_state  = S_CONV;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (w_done) begin
                    n_idx   = IDX_W'(NUM_DIGITS - 1);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if ((w_digit != 4'd0) || (r_idx == '0)) begin
                    n_byte  = ASCII_ZERO + {4'd0, w_digit};
                    n_final = (r_idx == '0);
                    n_hi    = 1'b1;
                    n_state = S_SEND;
                end else begin
                    n_idx = w_idx_dec;
                end
            end
            S_SEND: begin
                if (o_lcd.ready) begin
                    if (r_hi) begin
                        n_hi = 1'b0;
                    end else if (r_is_num && !r_final) begin
                        n_idx   = w_idx_dec;
                        n_byte  = ASCII_ZERO + {4'd0, w_next_digit};
                        n_final = (w_idx_dec == '0);
                        n_hi    = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_rs     <= n_rs;
        r_hi     <= n_hi;
        r_final  <= n_final;
        r_is_num <= n_is_num;
        r_idx    <= n_idx;
    end

    a_ready_not_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_lcd.valid)
        else $error("Request channel is ready while a strobe beat is pending.");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lcd.valid && o_lcd.ready && o_lcd.last) |=> i_req.ready)
        else $error("Block did not return to idle after the final beat.");

    a_byte_next_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.command != CMD_NUMBER))
        |=> (o_lcd.valid && !o_lcd.last))
        else $error("Byte request did not start with a high nibble beat.");

    a_digit_is_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_lcd.valid && r_is_num && r_hi)
        |-> (o_lcd.register_select && (o_lcd.nibble == ASCII_ZERO[7:4])))
        else $error("Number beat is not an ASCII digit on the data register.");

endmodule
